@@ design/rklc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rklc_pkg
// Shared constants, key table and types for the running-key letter cipher.
// ----------------------------------------------------------------------------
package rklc_pkg;

  localparam int unsigned KeyLength    = 20;  // entries in use, 1..32
  localparam int unsigned KeyTableSize = 32;
  localparam int unsigned KeyPosW      = $clog2(KeyTableSize);

  localparam logic [7:0] SpaceCode    = 8'h20;
  localparam logic [7:0] LetterBase   = 8'h61;  // 'a'
  localparam logic [7:0] LetterLast   = 8'h7a;  // 'z'
  localparam logic [5:0] AlphabetSize = 6'd26;

  typedef logic [KeyPosW-1:0] key_pos_t;
  typedef logic [4:0]         letter_val_t;  // letter value 1..26

  // Control from the datapath to the key counter, one request at a time.
  typedef struct packed {
    logic advance;  // request leaves the input stage this cycle
    logic restart;  // request starts a message
    logic letter;   // request is a letter, so the key moves on
  } key_ctrl_t;

  // Fixed key; entries past twenty repeat the first ones.
  function automatic letter_val_t key_entry(input key_pos_t pos);
    letter_val_t k;
    unique case (pos)
      5'd0:  k = 5'd22;
      5'd1:  k = 5'd16;
      5'd2:  k = 5'd23;
      5'd3:  k = 5'd19;
      5'd4:  k = 5'd5;
      5'd5:  k = 5'd24;
      5'd6:  k = 5'd10;
      5'd7:  k = 5'd12;
      5'd8:  k = 5'd8;
      5'd9:  k = 5'd3;
      5'd10: k = 5'd25;
      5'd11: k = 5'd13;
      5'd12: k = 5'd4;
      5'd13: k = 5'd15;
      5'd14: k = 5'd11;
      5'd15: k = 5'd6;
      5'd16: k = 5'd20;
      5'd17: k = 5'd26;
      5'd18: k = 5'd21;
      5'd19: k = 5'd14;
      5'd20: k = 5'd22;
      5'd21: k = 5'd16;
      5'd22: k = 5'd23;
      5'd23: k = 5'd19;
      5'd24: k = 5'd5;
      5'd25: k = 5'd24;
      5'd26: k = 5'd10;
      5'd27: k = 5'd12;
      5'd28: k = 5'd8;
      5'd29: k = 5'd3;
      5'd30: k = 5'd25;
      5'd31: k = 5'd13;
      default: k = 5'd22;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

@@ design/rklc_key_ctr.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rklc_key_ctr
// Key position counter with message restart and wrap, plus key table lookup.
// ----------------------------------------------------------------------------
module rklc_key_ctr (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire rklc_pkg::key_ctrl_t  ctrl_i,
  output rklc_pkg::letter_val_t     key_o,
  output rklc_pkg::key_pos_t        pos_o
);
  import rklc_pkg::*;

  key_pos_t         pos_q, pos_d;
  key_pos_t         pos_eff;
  logic [KeyPosW:0] pos_inc;

  // A message start takes effect before the request itself is ciphered.
  assign pos_eff = ctrl_i.restart ? '0 : pos_q;
  assign pos_inc = {1'b0, pos_eff} + {{KeyPosW{1'b0}}, 1'b1};
  assign key_o   = key_entry(pos_eff);
  assign pos_o   = pos_q;

  always_comb begin
    pos_d = pos_q;
    if (ctrl_i.advance) begin
      if (!ctrl_i.letter) begin
        pos_d = pos_eff;
      end else if (pos_inc >= (KeyPosW+1)'(KeyLength)) begin
        pos_d = '0;
      end else begin
        pos_d = pos_inc[KeyPosW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule
`default_nettype wire

@@ design/rklc_cipher_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rklc_cipher_core
// Modular add or subtract of the key value on letters; other bytes pass through.
// ----------------------------------------------------------------------------
module rklc_cipher_core (
  input  wire logic                   char_is_letter_i,
  input  wire logic [7:0]             char_code_i,
  input  wire rklc_pkg::letter_val_t  key_i,
  input  wire logic                   decrypt_i,
  output logic [7:0]                  out_code_o
);
  import rklc_pkg::*;

  logic [7:0] offs;
  logic [5:0] val;
  logic [5:0] sum;
  logic [5:0] res;

  assign offs = char_code_i - LetterBase;
  assign val  = {1'b0, offs[4:0]} + 6'd1;

  always_comb begin
    if (decrypt_i) begin
      sum = val + AlphabetSize - {1'b0, key_i};
    end else begin
      sum = val + {1'b0, key_i};
    end
    // Wrap back into 1..26.
    res = (sum > AlphabetSize) ? sum - AlphabetSize : sum;
    out_code_o = char_is_letter_i ? (LetterBase + {2'b00, res} - 8'd1) : char_code_i;
  end

endmodule
`default_nettype wire

@@ design/running_key_letter_cipher.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// running_key_letter_cipher
// Running-key letter cipher over lowercase ASCII with a fixed key table.
// ----------------------------------------------------------------------------
// Takes one ASCII byte per request and returns at most one byte. Letters a..z
// are shifted by the current key entry (added when decrypt_mode is 0,
// subtracted when it is 1) with wrap inside the alphabet, and each letter
// moves the key to its next entry, wrapping after the last one. A request
// with message_start set restarts the key at its first entry. A space gives
// no result; every other non-letter byte comes back unchanged and leaves the
// key where it is. out_valid_o rises once the result register is loaded;
// one request per cycle is taken while in_stall_o is low, the only loop being
// the five-bit key position register, updated as a request leaves the input
// register. Write decrypt_mode only while no request is in flight.
// ----------------------------------------------------------------------------
module running_key_letter_cipher (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Configuration
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  // Input channel
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] char_code_i,
  input  wire logic       message_start_i,
  // Output channel
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_code_o
);
  import rklc_pkg::*;

  // Mode register
  logic decrypt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decrypt_q <= 1'b0;
    end else if (cfg_we_i) begin
      decrypt_q <= cfg_wdata_i;
    end
  end

  // Input register: hold the accepted request until it can move on.
  logic       s1_valid_q;
  logic [7:0] s1_char_q;
  logic       s1_start_q;
  logic       s1_is_space;
  logic       s1_is_letter;
  logic       s1_advance;
  logic       in_accept;
  logic       out_free;
  logic       out_load;

  assign s1_is_space  = (s1_char_q == SpaceCode);
  assign s1_is_letter = (s1_char_q >= LetterBase) && (s1_char_q <= LetterLast);

  // The output register is free when empty or being drained this cycle.
  assign out_free   = !out_valid_o || !out_stall_i;
  // A space only updates the key state, so it never waits on the output.
  assign s1_advance = s1_valid_q && (s1_is_space || out_free);
  assign out_load   = s1_advance && !s1_is_space;
  assign in_stall_o = s1_valid_q && !s1_advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_char_q  <= char_code_i;
      s1_start_q <= message_start_i;
    end
  end

  // Key counter: advance as the request leaves the input register.
  key_ctrl_t   key_ctrl;
  letter_val_t key_val;
  key_pos_t    key_pos;

  assign key_ctrl.advance = s1_advance;
  assign key_ctrl.restart = s1_start_q;
  assign key_ctrl.letter  = s1_is_letter;

  rklc_key_ctr u_key_ctr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (key_ctrl),
    .key_o  (key_val),
    .pos_o  (key_pos)
  );

  // Cipher datapath
  logic [7:0] res_code;

  rklc_cipher_core u_cipher_core (
    .char_is_letter_i (s1_is_letter),
    .char_code_i      (s1_char_q),
    .key_i            (key_val),
    .decrypt_i        (decrypt_q),
    .out_code_o       (res_code)
  );

  // Result register
  logic       out_valid_q;
  logic [7:0] out_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_code_q <= res_code;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_code_o  = out_code_q;

`ifndef SYNTHESIS
  // Key position always stays inside the used part of the key table.
  a_key_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_pos < KeyPosW'(KeyLength))
    else $error("key position out of range");

  // A letter always leaves the datapath as a lowercase letter.
  a_letter_stays_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && s1_is_letter |-> (res_code >= LetterBase) && (res_code <= LetterLast))
    else $error("enciphered letter outside a..z");

  // The input side stalls only while a request is held and cannot move on.
  a_stall_needs_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && !s1_is_space && out_valid_o && out_stall_i)
    else $error("input stalled without a blocked request");

  // A space never loads the result register.
  a_space_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_is_space && !out_stall_i |=> !out_valid_o)
    else $error("space produced a result");
`endif

endmodule
`default_nettype wire
